/* hdl/tfti_pkg.sv */
// Shared types, widths and helpers for the tensor flip tile index unit.
// No dependencies; every other file imports this package.
`default_nettype none

package tfti_pkg;

  // Field and register widths
  localparam int unsigned ShapeW  = 16;
  localparam int unsigned IdxW    = 32;
  localparam int unsigned StrideW = 32;
  localparam int unsigned CfgIdxW = 4;

  // Tensor rank handled by the unit
  localparam int unsigned NumDims = 4;

  // Mirrored dimensions
  localparam int unsigned FlipCount = 2;
  localparam int unsigned FlipDims [FlipCount] = '{2, 3};

  // Division chain: each cell retires this many quotient bits
  localparam int unsigned BitsPerCell  = 4;
  localparam int unsigned CellsPerDim  = IdxW / BitsPerCell;
  localparam int unsigned NumCells     = NumDims * CellsPerDim;

  // Mirror, multiply, pair add, final add
  localparam int unsigned CombineStages = 4;
  localparam int unsigned Latency       = NumCells + CombineStages;

  // Configuration register indexes
  typedef logic [CfgIdxW-1:0] cfg_idx_t;
  localparam cfg_idx_t RegShape0  = 4'd0;
  localparam cfg_idx_t RegShape1  = 4'd1;
  localparam cfg_idx_t RegShape2  = 4'd2;
  localparam cfg_idx_t RegShape3  = 4'd3;
  localparam cfg_idx_t RegStride0 = 4'd4;
  localparam cfg_idx_t RegStride1 = 4'd5;
  localparam cfg_idx_t RegStride2 = 4'd6;
  localparam cfg_idx_t RegStride3 = 4'd7;

  typedef logic [NumDims-1:0][ShapeW-1:0]  shape_arr_t;
  typedef logic [NumDims-1:0][StrideW-1:0] stride_arr_t;

  // Word carried down the division chain
  typedef struct packed {
    logic [ShapeW-1:0] rem;    // partial remainder of the current dimension
    logic [IdxW-1:0]   quo;    // dividend bits still to go, quotient bits shifted in
    shape_arr_t        coord;  // coordinates of finished dimensions
  } word_t;

  function automatic logic is_flipped(int unsigned dim);
    logic hit;
    hit = 1'b0;
    for (int unsigned j = 0; j < FlipCount; j++) begin
      if (FlipDims[j] == dim) begin
        hit = 1'b1;
      end
    end
    return hit;
  endfunction

endpackage

`default_nettype wire

/* hdl/tfti_div_cell.sv */
// One cell of the division chain: retires BitsPerCell restoring division steps.
// Depends on tfti_pkg.
`default_nettype none

module tfti_div_cell (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  input  tfti_pkg::word_t           word_i,
  input  logic [tfti_pkg::ShapeW-1:0] divisor_i,
  output logic                      valid_o,
  output tfti_pkg::word_t           word_o
);
  import tfti_pkg::*;

  logic              valid_q;
  word_t             word_d;
  word_t             word_q;
  logic [ShapeW:0]   trial;
  logic [ShapeW-1:0] rem;
  logic [IdxW-1:0]   quo;

  // Remainder stays below the divisor, so one compare and subtract per bit.
  always_comb begin
    rem   = word_i.rem;
    quo   = word_i.quo;
    trial = '0;
    for (int unsigned s = 0; s < BitsPerCell; s++) begin
      trial = {rem, quo[IdxW-1]};
      quo   = {quo[IdxW-2:0], 1'b0};
      if (trial >= {1'b0, divisor_i}) begin
        trial  = trial - {1'b0, divisor_i};
        quo[0] = 1'b1;
      end
      rem = trial[ShapeW-1:0];
    end
    word_d       = word_i;
    word_d.rem   = rem;
    word_d.quo   = quo;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign valid_o = valid_q;
  assign word_o  = word_q;

endmodule

`default_nettype wire

/* hdl/tfti_combine.sv */
// Mirrors flipped coordinates and sums coordinate times stride over four stages.
// Depends on tfti_pkg.
`default_nettype none

module tfti_combine (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  input  tfti_pkg::shape_arr_t      coord_i,
  input  tfti_pkg::shape_arr_t      count_i,
  input  tfti_pkg::stride_arr_t     stride_i,
  output logic                      valid_o,
  output logic [tfti_pkg::IdxW-1:0] sum_o
);
  import tfti_pkg::*;

  localparam int unsigned NumPairs = NumDims / 2;

  logic [CombineStages-1:0]           valid_q;
  shape_arr_t                         mir_d, mir_q;
  logic [NumDims-1:0][IdxW-1:0]       prod_d, prod_q;
  logic [NumPairs-1:0][IdxW-1:0]      pair_d, pair_q;
  logic [IdxW-1:0]                    sum_d, sum_q;

  always_comb begin
    for (int unsigned d = 0; d < NumDims; d++) begin
      mir_d[d] = is_flipped(d) ? (count_i[d] - coord_i[d] - ShapeW'(1)) : coord_i[d];
    end
  end

  // Keep the low word of each product; the sum wraps the same way.
  always_comb begin
    for (int unsigned d = 0; d < NumDims; d++) begin
      prod_d[d] = {{(IdxW-ShapeW){1'b0}}, mir_q[d]} * stride_i[d];
    end
  end

  always_comb begin
    for (int unsigned p = 0; p < NumPairs; p++) begin
      pair_d[p] = prod_q[2*p] + prod_q[2*p+1];
    end
  end

  always_comb begin
    sum_d = '0;
    for (int unsigned p = 0; p < NumPairs; p++) begin
      sum_d = sum_d + pair_q[p];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[CombineStages-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    mir_q  <= mir_d;
    prod_q <= prod_d;
    pair_q <= pair_d;
    sum_q  <= sum_d;
  end

  assign valid_o = valid_q[CombineStages-1];
  assign sum_o   = sum_q;

endmodule

`default_nettype wire

/* hdl/tensor_flip_tile_index_unit.sv */
// Top level of the tensor flip tile index unit: config registers, division chain, combine.
// Depends on tfti_pkg, tfti_div_cell and tfti_combine.
`default_nettype none

// Maps a destination tile index to the source tile index of a tensor flip.
// The unit takes one word on every clock edge where start is high; busy is
// always low, so a new index may follow in the very next cycle. Each result
// shows on source_index_o with valid_o high for exactly one cycle. Results
// come back in start order. The receiver cannot hold results off, so it must
// take every strobe. The pipeline is the division chain of 32 cells, each
// retiring four quotient bits of the mixed-radix decode (eight cells per
// dimension, four dimensions), followed by four stages of mirror, multiply,
// pair add and final add. Write shape and stride registers only while no
// result is pending; a shape of zero behaves as a shape of one.
module tensor_flip_tile_index_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic [tfti_pkg::IdxW-1:0]    dest_index_i,
  output logic                         valid_o,
  output logic [tfti_pkg::IdxW-1:0]    source_index_o,
  input  logic                         cfg_we_i,
  input  logic [tfti_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [tfti_pkg::StrideW-1:0] cfg_wdata_i
);
  import tfti_pkg::*;

  shape_arr_t  shape_q;
  stride_arr_t stride_q;
  shape_arr_t  count;

  logic  cell_vin  [NumCells];
  word_t cell_win  [NumCells];
  logic  cell_vout [NumCells];
  word_t cell_wout [NumCells];

  shape_arr_t final_coord;

  // The chain takes a word every cycle.
  assign busy = 1'b0;

  // Configuration registers; writes beyond the list drop.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int unsigned d = 0; d < NumDims; d++) begin
        shape_q[d]  <= ShapeW'(1);
        stride_q[d] <= '0;
      end
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegShape0:  shape_q[0]  <= cfg_wdata_i[ShapeW-1:0];
        RegShape1:  shape_q[1]  <= cfg_wdata_i[ShapeW-1:0];
        RegShape2:  shape_q[2]  <= cfg_wdata_i[ShapeW-1:0];
        RegShape3:  shape_q[3]  <= cfg_wdata_i[ShapeW-1:0];
        RegStride0: stride_q[0] <= cfg_wdata_i;
        RegStride1: stride_q[1] <= cfg_wdata_i;
        RegStride2: stride_q[2] <= cfg_wdata_i;
        RegStride3: stride_q[3] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // A zero count acts as one: coordinate zero, quotient passes through.
  always_comb begin
    for (int unsigned d = 0; d < NumDims; d++) begin
      count[d] = (shape_q[d] == '0) ? ShapeW'(1) : shape_q[d];
    end
  end

  // Division chain, least significant dimension first. At each dimension
  // boundary, bank the remainder as that dimension's coordinate, clear the
  // partial remainder and advance the quotient as the next dividend.
  for (genvar k = 0; k < NumCells; k++) begin : g_cell
    localparam int unsigned Dim  = NumDims - 1 - (k / CellsPerDim);
    localparam int unsigned Step = k % CellsPerDim;

    if (k == 0) begin : g_head
      always_comb begin
        cell_vin[k]       = start && !busy;
        cell_win[k].rem   = '0;
        cell_win[k].quo   = dest_index_i;
        cell_win[k].coord = '0;
      end
    end else if (Step == 0) begin : g_boundary
      always_comb begin
        cell_vin[k]                = cell_vout[k-1];
        cell_win[k].rem            = '0;
        cell_win[k].quo            = cell_wout[k-1].quo;
        cell_win[k].coord          = cell_wout[k-1].coord;
        cell_win[k].coord[Dim + 1] = cell_wout[k-1].rem;
      end
    end else begin : g_link
      always_comb begin
        cell_vin[k] = cell_vout[k-1];
        cell_win[k] = cell_wout[k-1];
      end
    end

    tfti_div_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .valid_i   (cell_vin[k]),
      .word_i    (cell_win[k]),
      .divisor_i (count[Dim]),
      .valid_o   (cell_vout[k]),
      .word_o    (cell_wout[k])
    );
  end

  // Dimension 0 remainder closes the decode; drop the quotient above it.
  always_comb begin
    final_coord    = cell_wout[NumCells-1].coord;
    final_coord[0] = cell_wout[NumCells-1].rem;
  end

  tfti_combine u_combine (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (cell_vout[NumCells-1]),
    .coord_i  (final_coord),
    .count_i  (count),
    .stride_i (stride_q),
    .valid_o  (valid_o),
    .sum_o    (source_index_o)
  );

endmodule

`default_nettype wire

/* hdl/tfti_checker.sv */
// Port-level checker for the tensor flip tile index unit, bound to the top level.
// Depends on tfti_pkg and tensor_flip_tile_index_unit.
`default_nettype none

module tfti_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic valid_o
);
  import tfti_pkg::*;

  // Every accepted word yields its result after the fixed latency.
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##Latency valid_o)
    else $error("accepted word produced no result after the chain latency");

  // No result appears without a word accepted the latency earlier.
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(start && !busy, Latency))
    else $error("result strobe without a matching accepted word");

  // Reset empties the pipeline at once.
  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |-> !valid_o)
    else $error("result strobe while in reset");

endmodule

bind tensor_flip_tile_index_unit tfti_checker u_tfti_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start   (start),
  .busy    (busy),
  .valid_o (valid_o)
);

`default_nettype wire

/* dv/tensor_flip_tile_index_unit_tb.sv */
// Self-checking bench for tensor_flip_tile_index_unit: directed and random tile indexes
// across many shape/stride settings, checked against a built-in index remap predictor.
// Depends on tfti_pkg and the RTL of tensor_flip_tile_index_unit.
`default_nettype none

module tensor_flip_tile_index_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tfti_pkg::*;

  // Run control
  localparam int unsigned CycleLimit     = 400_000;
  localparam int unsigned RandomSettings = 10;
  localparam int unsigned WordsPerSet    = 185;
  localparam int unsigned MaxReports     = 10;

  // Dimensions 2 and 3 are mirrored (bit d set = dimension d flipped)
  localparam logic [NumDims-1:0] MirrorMask = 4'b1100;

  // First register index past the stride bank; writes from here up are dropped
  localparam cfg_idx_t FirstUnusedReg = cfg_idx_t'(RegStride3 + 1);

  typedef struct {
    logic [IdxW-1:0] dest;
    logic [IdxW-1:0] source;
  } tile_remap_t;

  // DUT pins, all known from time zero; reset pulses low just after time zero
  logic                clk_i          = 1'b0;
  logic                rst_ni         = 1'b1;
  logic                start          = 1'b0;
  logic                busy;
  logic [IdxW-1:0]     dest_index_i   = '0;
  logic                valid_o;
  logic [IdxW-1:0]     source_index_o;
  logic                cfg_we_i       = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i      = '0;
  logic [StrideW-1:0]  cfg_wdata_i    = '0;

  // Shadow copy of the register file as the block should hold it
  logic [ShapeW-1:0]  shape_q  [NumDims];
  logic [StrideW-1:0] stride_q [NumDims];

  // Words waiting to be sent, and remaps waiting to come back
  logic [IdxW-1:0] pending_dest [$];
  tile_remap_t     remap_expect [$];

  int unsigned cycle_cnt    = 0;
  int unsigned words_sent   = 0;
  int unsigned results_seen = 0;
  int unsigned settings_cnt = 0;
  int unsigned mismatch_cnt = 0;
  int unsigned error_cnt    = 0;

  // Sender burst shaping
  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;

  tensor_flip_tile_index_unit u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .dest_index_i   (dest_index_i),
    .valid_o        (valid_o),
    .source_index_o (source_index_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Decode the destination index mixed-radix (dimension 3 least significant), drop
  // whatever quotient is left above dimension 0, mirror the flipped coordinates and
  // rebuild the source index as coordinate times stride, wrapping at 32 bits.
  function automatic logic [IdxW-1:0] flip_source_index(input logic [IdxW-1:0] dest);
    logic [IdxW-1:0] rem;
    logic [IdxW-1:0] count;
    logic [IdxW-1:0] crd;
    logic [IdxW-1:0] acc;
    logic [IdxW-1:0] coord [NumDims];
    rem = dest;
    acc = '0;
    for (int d = NumDims - 1; d >= 0; d--) begin
      count = IdxW'(shape_q[d]);
      // A zero count behaves like one: coordinate 0, quotient passes through
      if (count == '0) begin
        coord[d] = '0;
      end else begin
        coord[d] = rem % count;
        rem      = rem / count;
      end
    end
    for (int d = 0; d < NumDims; d++) begin
      count = IdxW'(shape_q[d]);
      crd   = coord[d];
      if (MirrorMask[d] && count != '0) begin
        crd = count - crd - 1;
      end
      acc = acc + crd * stride_q[d];
    end
    return acc;
  endfunction

  // Mostly indexes inside the shape so every coordinate moves, plus full-range
  // indexes that spill past dimension 0 and the edges of both.
  function automatic logic [IdxW-1:0] pick_dest_index();
    longint unsigned span;
    int unsigned     pick;
    span = 1;
    for (int d = 0; d < NumDims; d++) begin
      span = span * ((shape_q[d] == '0) ? 1 : longint'(shape_q[d]));
    end
    if (span > 64'hFFFF_FFFF) begin
      span = 64'hFFFF_FFFF;
    end
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      return IdxW'($urandom_range(0, int'(span - 1)));
    end else if (pick < 85) begin
      return $urandom();
    end else begin
      case ($urandom_range(0, 3))
        0: return '0;
        1: return '1;
        2: return IdxW'(span - 1);
        default: return IdxW'(span);
      endcase
    end
  endfunction

  // Random gap between bursts; a third of the time none, so bursts run back to back
  function automatic int unsigned pick_gap();
    return ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
  endfunction

  // Block until nothing is queued, nothing is on the start line and every remap
  // has come back. Sampled on the falling edge so the clocked blocks have settled.
  task automatic wait_drained();
    do begin
      @(negedge clk_i);
    end while (pending_dest.size() != 0 || start || remap_expect.size() != 0);
  endtask

  // Load a full setting: all four shapes (junk in the upper data bits, which the
  // block must mask off), all four strides, and one write to an unused index
  // that must leave the registers alone.
  task automatic apply_setting(input logic [ShapeW-1:0] s0, input logic [ShapeW-1:0] s1,
                               input logic [ShapeW-1:0] s2, input logic [ShapeW-1:0] s3,
                               input logic [StrideW-1:0] t0, input logic [StrideW-1:0] t1,
                               input logic [StrideW-1:0] t2, input logic [StrideW-1:0] t3);
    logic [ShapeW-1:0]  shp [NumDims];
    logic [StrideW-1:0] str [NumDims];
    logic [StrideW-1:0] junk;
    shp = '{s0, s1, s2, s3};
    str = '{t0, t1, t2, t3};
    wait_drained();
    for (int d = 0; d < NumDims; d++) begin
      junk = $urandom();
      @(posedge clk_i);
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= RegShape0 + cfg_idx_t'(d);
      cfg_wdata_i <= {junk[StrideW-1:ShapeW], shp[d]};
      shape_q[d]  = shp[d];
    end
    for (int d = 0; d < NumDims; d++) begin
      @(posedge clk_i);
      cfg_idx_i   <= RegStride0 + cfg_idx_t'(d);
      cfg_wdata_i <= str[d];
      stride_q[d] = str[d];
    end
    @(posedge clk_i);
    cfg_idx_i   <= FirstUnusedReg + cfg_idx_t'($urandom_range(0, 7));
    cfg_wdata_i <= $urandom();
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    settings_cnt++;
    // Queue the next words only once the last write has landed
    @(negedge clk_i);
  endtask

  // Random setting: small counts dominate so in-shape indexes exercise every
  // dimension; zero and full-width counts and extreme strides mixed in.
  function automatic logic [ShapeW-1:0] pick_shape();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) return ShapeW'($urandom_range(1, 8));
    if (pick < 75) return '0;
    if (pick < 90) return ShapeW'($urandom_range(1, 65535));
    return (pick < 95) ? '1 : ShapeW'(1);
  endfunction

  function automatic logic [StrideW-1:0] pick_stride();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 40) return StrideW'($urandom_range(0, 64));
    if (pick < 80) return $urandom();
    return (pick < 90) ? '1 : '0;
  endfunction

  // Driver: hand out queued words in bursts and record what each accepted word
  // should produce. Config only changes while drained, so the shadow is current.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start      <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      if (start && !busy) begin
        remap_expect.push_back('{dest: dest_index_i, source: flip_source_index(dest_index_i)});
        words_sent++;
      end
      if (start && busy) begin
        // hold the current word until the block takes it
      end else if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (pending_dest.size() > 0) begin
        start        <= 1'b1;
        dest_index_i <= pending_dest.pop_front();
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 40);
          gap_left   = pick_gap();
        end else begin
          burst_left--;
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: every strobe must match the oldest outstanding remap
  always @(posedge clk_i) begin
    if (rst_ni && valid_o) begin
      results_seen++;
      if (remap_expect.size() == 0) begin
        error_cnt++;
        if (mismatch_cnt < MaxReports) begin
          $display("unexpected result: source_index %h with nothing outstanding",
                   source_index_o);
        end
        mismatch_cnt++;
      end else begin
        tile_remap_t exp_remap;
        exp_remap = remap_expect.pop_front();
        if (source_index_o !== exp_remap.source) begin
          error_cnt++;
          if (mismatch_cnt < MaxReports) begin
            $display("source_index mismatch for dest %h: expected %h, got %h",
                     exp_remap.dest, exp_remap.source, source_index_o);
          end
          mismatch_cnt++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d remaps outstanding",
               cycle_cnt, remap_expect.size());
      $display("FAIL tensor_flip_tile_index_unit");
      $finish;
    end
  end

  initial begin
    for (int d = 0; d < NumDims; d++) begin
      shape_q[d]  = ShapeW'(1);
      stride_q[d] = '0;
    end
    // Drop reset before the first edge so every resettable flop clears at once
    #1 rst_ni = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset values: every count is one and every stride zero, so all map to 0
    pending_dest.push_back('0);
    pending_dest.push_back('1);
    pending_dest.push_back(32'd12345);

    // Plain 3x4x5x6 row-major layout: corners, carries, past the shape, top bit
    apply_setting(16'd3, 16'd4, 16'd5, 16'd6, 32'd120, 32'd30, 32'd6, 32'd1);
    pending_dest.push_back(32'd0);
    pending_dest.push_back(32'd1);
    pending_dest.push_back(32'd5);
    pending_dest.push_back(32'd6);
    pending_dest.push_back(32'd359);
    pending_dest.push_back(32'd360);
    pending_dest.push_back(32'h8000_0000);
    pending_dest.push_back('1);

    // Zero counts in dimension 0 and a mirrored dimension act as one
    apply_setting(16'd0, 16'd3, 16'd0, 16'd4, 32'd1000, 32'd100, 32'd10, 32'd1);
    pending_dest.push_back(32'd0);
    pending_dest.push_back(32'd11);
    pending_dest.push_back(32'd12);
    pending_dest.push_back('1);

    // Widest counts and strides: products and the sum wrap at 32 bits
    apply_setting('1, '1, '1, '1, '1, '1, '1, '1);
    pending_dest.push_back('0);
    pending_dest.push_back('1);
    pending_dest.push_back(32'h0000_FFFF);
    pending_dest.push_back(32'hFFFF_0000);

    // Binary shape: both mirrored bits flip, first wrap past the shape
    apply_setting(16'd2, 16'd2, 16'd2, 16'd2, 32'd8, 32'd4, 32'd2, 32'd1);
    pending_dest.push_back(32'd0);
    pending_dest.push_back(32'd15);
    pending_dest.push_back(32'd16);

    // Random settings, each followed by a run of random words
    for (int unsigned s = 0; s < RandomSettings; s++) begin
      apply_setting(pick_shape(), pick_shape(), pick_shape(), pick_shape(),
                    pick_stride(), pick_stride(), pick_stride(), pick_stride());
      for (int unsigned w = 0; w < WordsPerSet; w++) begin
        pending_dest.push_back(pick_dest_index());
      end
    end

    // Drain, then watch a while longer for stray strobes
    wait_drained();
    repeat (Latency + 8) @(posedge clk_i);
    @(negedge clk_i);
    error_cnt += remap_expect.size();
    if (remap_expect.size() != 0) begin
      $display("%0d remaps never came back", remap_expect.size());
    end

    $display("covered %0d tile indexes over %0d register settings, %0d results checked",
             words_sent, settings_cnt + 1, results_seen);
    $display("mismatches: %0d, total errors: %0d", mismatch_cnt, error_cnt);
    if (error_cnt == 0) begin
      $display("PASS tensor_flip_tile_index_unit");
    end else begin
      $display("FAIL tensor_flip_tile_index_unit");
    end
    $finish;
  end

endmodule

`default_nettype wire
